/* rtl/psh_pkg.sv */
// ----------------------------------------------------------------------------
// psh_pkg: shared types and constants for the partial shuffle engine
// Mode and status codes, controller states, command/status bundles.
// ----------------------------------------------------------------------------
package psh_pkg;

    // default sizing
    localparam int DEF_MAX_ENTRIES = 1024;
    localparam int DEF_RANDOM_BITS = 31;

    // fixed field widths
    localparam int VALUE_W   = 10;
    localparam int REG_W     = 11;
    localparam int RWORD_W   = 31;
    localparam int CFG_IDX_W = 1;
    localparam int STATUS_W  = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SEQ_LEN   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DRAW_CNT  = 1'd1;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE     = 2'd2;

    typedef enum logic [1:0] {
        MODE_RESTART = 2'd0,
        MODE_DRAW    = 2'd1,
        MODE_READ    = 2'd2,
        MODE_NONE    = 2'd3
    } psh_mode_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_FILL,
        S_DIV,
        S_RD_SWAP,
        S_WR_K,
        S_WR_J,
        S_RD_ENTRY,
        S_RESULT
    } psh_state_t;

    // controller -> datapath
    typedef struct packed {
        logic latch;      // capture input transaction
        logic decode;     // classify item, set status, reset counters
        logic div_start;  // launch modulo
        logic fill_wr;    // identity fill write
        logic rd_swap;    // read both swap entries
        logic wr_k;       // write entry k
        logic wr_j;       // write entry j, bump draw counter
        logic rd_entry;   // read entry for read item
        logic load_out;   // load result register
    } psh_cmd_t;

    // datapath -> controller
    typedef struct packed {
        psh_mode_t mode;
        logic      n_zero;
        logic      draw_ok;
        logic      read_ok;
        logic      fill_last;
        logic      div_done;
        logic      out_free;
    } psh_sts_t;

endpackage

/* rtl/psh_div.sv */
// ----------------------------------------------------------------------------
// psh_div: bit-serial remainder unit
// Restoring division, one dividend bit per cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
module psh_div
    import psh_pkg::*;
#(
    parameter int DVD_W = DEF_RANDOM_BITS,
    parameter int DSR_W = REG_W
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DSR_W-1:0] divisor,
    output logic             done,
    output logic [DSR_W-1:0] rem
);

    localparam int STEP_W = $clog2(DVD_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DVD_W-1:0]  dvd_reg, dvd_next;
    logic [DSR_W-1:0]  rem_reg, rem_next;
    logic [DSR_W:0]    trial;

    always_comb
    begin
        trial     = {rem_reg, dvd_reg[DVD_W-1]};
        busy_next = busy_reg;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(DVD_W);
            dvd_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next  = {dvd_reg[DVD_W-2:0], 1'b0};
            step_next = step_reg - STEP_W'(1);
            if (trial >= {1'b0, divisor})
                rem_next = DSR_W'(trial - {1'b0, divisor});
            else
                rem_next = DSR_W'(trial);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

/* rtl/psh_dp.sv */
// ----------------------------------------------------------------------------
// psh_dp: shuffle datapath
// Config registers, sequence store, draw counter, modulo unit, result register.
// ----------------------------------------------------------------------------
module psh_dp
    import psh_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int RANDOM_BITS = DEF_RANDOM_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data,
    input  psh_mode_t            in_mode,
    input  logic [RWORD_W-1:0]   in_random_word,
    input  logic [VALUE_W-1:0]   in_read_index,
    input  psh_cmd_t             cmd,
    output psh_sts_t             sts,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [VALUE_W-1:0]   out_entry_value,
    output logic [STATUS_W-1:0]  out_status,
    output logic                 out_draws_done
);

    localparam int ADDR_W = $clog2(MAX_ENTRIES);
    // largest n the 11-bit length register can express
    localparam int MAX_N  = (MAX_ENTRIES < 2047) ? MAX_ENTRIES : 2047;

    logic [REG_W-1:0]       seq_len_reg, seq_len_next;
    logic [REG_W-1:0]       draw_cnt_reg, draw_cnt_next;
    logic [REG_W-1:0]       cnt_reg, cnt_next;
    logic [REG_W-1:0]       idx_reg, idx_next;
    logic                   out_valid_reg, out_valid_next;

    psh_mode_t              mode_reg;
    logic [RANDOM_BITS-1:0] rword_reg;
    logic [VALUE_W-1:0]     ridx_reg;
    logic [REG_W-1:0]       j_reg;
    logic [STATUS_W-1:0]    res_status_reg, res_status_next;
    logic [VALUE_W-1:0]     out_entry_reg;
    logic [STATUS_W-1:0]    out_status_reg;
    logic                   out_done_reg;
    logic [ADDR_W-1:0]      rd_a_reg, rd_b_reg;

    logic [ADDR_W-1:0]      mem [MAX_ENTRIES];

    logic [REG_W-1:0]       n, limit, divisor, rem;
    logic                   draw_ok, read_ok, div_done, out_free;
    logic                   mem_we;
    logic [ADDR_W-1:0]      waddr, wdata, raddr_a;

    // effective length and draw limit
    assign n        = (seq_len_reg > REG_W'(MAX_N)) ? REG_W'(MAX_N) : seq_len_reg;
    assign limit    = (draw_cnt_reg < n) ? draw_cnt_reg : n;
    assign draw_ok  = cnt_reg < limit;
    assign read_ok  = {1'b0, ridx_reg} < n;
    assign divisor  = n - cnt_reg;
    assign out_free = !out_valid_reg || out_ready;

    psh_div #(
        .DVD_W (RANDOM_BITS),
        .DSR_W (REG_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (rword_reg),
        .divisor  (divisor),
        .done     (div_done),
        .rem      (rem)
    );

    always_comb
    begin
        sts.mode      = mode_reg;
        sts.n_zero    = (n == '0);
        sts.draw_ok   = draw_ok;
        sts.read_ok   = read_ok;
        sts.fill_last = (idx_reg == n - REG_W'(1));
        sts.div_done  = div_done;
        sts.out_free  = out_free;
    end

    // config and control registers
    always_comb
    begin
        seq_len_next  = seq_len_reg;
        draw_cnt_next = draw_cnt_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SEQ_LEN:  seq_len_next  = cfg_data;
                REG_DRAW_CNT: draw_cnt_next = cfg_data;
                default: ;
            endcase
        end

        cnt_next = cnt_reg;
        if (cmd.decode && mode_reg == MODE_RESTART)
            cnt_next = '0;
        else if (cmd.wr_j)
            cnt_next = cnt_reg + REG_W'(1);

        idx_next = idx_reg;
        if (cmd.decode)
            idx_next = '0;
        else if (cmd.fill_wr)
            idx_next = idx_reg + REG_W'(1);

        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;

        res_status_next = res_status_reg;
        if (cmd.decode)
        begin
            case (mode_reg)
                MODE_DRAW: res_status_next = draw_ok ? STATUS_OK : STATUS_EXHAUSTED;
                MODE_READ: res_status_next = read_ok ? STATUS_OK : STATUS_RANGE;
                default:   res_status_next = STATUS_OK;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_len_reg   <= REG_W'(1024);
            draw_cnt_reg  <= REG_W'(1024);
            cnt_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seq_len_reg   <= seq_len_next;
            draw_cnt_reg  <= draw_cnt_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            mode_reg  <= in_mode;
            rword_reg <= RANDOM_BITS'(in_random_word);
            ridx_reg  <= in_read_index;
        end
        if (div_done)
            j_reg <= cnt_reg + rem;
        res_status_reg <= res_status_next;
        if (cmd.load_out)
        begin
            out_entry_reg  <= (mode_reg == MODE_READ && res_status_reg == STATUS_OK)
                              ? VALUE_W'(rd_a_reg) : '0;
            out_status_reg <= res_status_reg;
            out_done_reg   <= !draw_ok;
        end
    end

    // sequence store: one write port, two registered read ports
    always_comb
    begin
        mem_we  = cmd.fill_wr || cmd.wr_k || cmd.wr_j;
        waddr   = ADDR_W'(idx_reg);
        wdata   = ADDR_W'(idx_reg);
        if (cmd.wr_k)
        begin
            waddr = ADDR_W'(cnt_reg);
            wdata = rd_b_reg;
        end
        else if (cmd.wr_j)
        begin
            waddr = ADDR_W'(j_reg);
            wdata = rd_a_reg;
        end
        raddr_a = cmd.rd_swap ? ADDR_W'(cnt_reg) : ADDR_W'(ridx_reg);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[waddr] <= wdata;
        if (cmd.rd_swap || cmd.rd_entry)
            rd_a_reg <= mem[raddr_a];
        if (cmd.rd_swap)
            rd_b_reg <= mem[ADDR_W'(j_reg)];
    end

    assign out_valid       = out_valid_reg;
    assign out_entry_value = out_entry_reg;
    assign out_status      = out_status_reg;
    assign out_draws_done  = out_done_reg;

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result loaded over a pending transaction");

    a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fill_wr |-> idx_reg < n)
        else $error("fill write past sequence end");

    a_swap_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_swap |-> (j_reg < n && cnt_reg < n && j_reg >= cnt_reg))
        else $error("swap indexes out of range");

endmodule

/* rtl/psh_ctrl.sv */
// ----------------------------------------------------------------------------
// psh_ctrl: shuffle controller
// Sequences restart fill, draw/swap and read items; issues datapath commands.
// ----------------------------------------------------------------------------
module psh_ctrl
    import psh_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  psh_sts_t sts,
    output psh_cmd_t cmd
);

    psh_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = S_DECODE;
            S_DECODE:
                unique case (sts.mode)
                    MODE_RESTART: state_next = sts.n_zero  ? S_RESULT : S_FILL;
                    MODE_DRAW:    state_next = sts.draw_ok ? S_DIV : S_RESULT;
                    MODE_READ:    state_next = sts.read_ok ? S_RD_ENTRY : S_RESULT;
                    default:      state_next = S_RESULT;
                endcase
            S_FILL:
                if (sts.fill_last)
                    state_next = S_RESULT;
            S_DIV:
                if (sts.div_done)
                    state_next = S_RD_SWAP;
            S_RD_SWAP:  state_next = S_WR_K;
            S_WR_K:     state_next = S_WR_J;
            S_WR_J:     state_next = S_RESULT;
            S_RD_ENTRY: state_next = S_RESULT;
            S_RESULT:
                if (sts.out_free)
                    state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready      = (state_reg == S_IDLE);
        cmd           = '0;
        cmd.latch     = (state_reg == S_IDLE) && in_valid;
        cmd.decode    = (state_reg == S_DECODE);
        cmd.div_start = (state_reg == S_DECODE) && (sts.mode == MODE_DRAW) && sts.draw_ok;
        cmd.fill_wr   = (state_reg == S_FILL);
        cmd.rd_swap   = (state_reg == S_RD_SWAP);
        cmd.wr_k      = (state_reg == S_WR_K);
        cmd.wr_j      = (state_reg == S_WR_J);
        cmd.rd_entry  = (state_reg == S_RD_ENTRY);
        cmd.load_out  = (state_reg == S_RESULT) && sts.out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

/* rtl/partial_shuffle_engine.sv */
// ----------------------------------------------------------------------------
// partial_shuffle_engine: partial Fisher-Yates shuffle over a sequence store
// Restart fills entries 0..n-1 with the identity, draw swaps entry k with
// entry k + (r mod (n-k)), read returns one entry. One result per item.
//
//   channel   direction  transaction                  payload
//   s_axis    in         valid & ready                tdata: random_word,
//                                                     read_index; tuser: mode
//   m_axis    out        valid & ready                tdata: entry_value;
//                                                     tuser: status, draws_done
//   cfg       in         cfg_we (every cycle)         cfg_index, cfg_data
//
// The store has one write port, so the restart fill writes one entry per
// cycle and a swap takes two writes, first entry k and then entry j.
// Reset clears control and restores the length and draw registers to 1024;
// the store contents are undefined until the first restart.
// A result waiting on m_axis does not block acceptance of the next item; the
// engine only stalls when a second result is ready and the first is unread.
// ----------------------------------------------------------------------------
module partial_shuffle_engine
    import psh_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int RANDOM_BITS = DEF_RANDOM_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,   // 0 sequence_length, 1 draw_count
    input  logic [REG_W-1:0]     cfg_data,
    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [47:0]          s_axis_tdata,  // [30:0] random_word, [40:31] read_index
    input  logic [1:0]           s_axis_tuser,  // [1:0] mode
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [15:0]          m_axis_tdata,  // [9:0] entry_value
    output logic [2:0]           m_axis_tuser   // [1:0] status, [2] draws_done
);

    psh_cmd_t            cmd;
    psh_sts_t            sts;
    logic [VALUE_W-1:0]  entry_value;
    logic [STATUS_W-1:0] status;
    logic                draws_done;

    psh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    psh_dp #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .RANDOM_BITS (RANDOM_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_mode         (psh_mode_t'(s_axis_tuser)),
        .in_random_word  (s_axis_tdata[RWORD_W-1:0]),
        .in_read_index   (s_axis_tdata[RWORD_W+VALUE_W-1:RWORD_W]),
        .cmd             (cmd),
        .sts             (sts),
        .out_ready       (m_axis_tready),
        .out_valid       (m_axis_tvalid),
        .out_entry_value (entry_value),
        .out_status      (status),
        .out_draws_done  (draws_done)
    );

    assign m_axis_tdata = {6'd0, entry_value};
    assign m_axis_tuser = {draws_done, status};

endmodule

/* verif/shuffle_checker.sv */
// ----------------------------------------------------------------------------
// shuffle_checker: result checker for the partial shuffle engine
// Follows config writes and input transactions, keeps its own copy of the
// sequence store and draw counter, and compares every result transaction
// with the oldest predicted answer.
// ----------------------------------------------------------------------------
module shuffle_checker
    import psh_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [47:0]          s_tdata,   // [30:0] random_word, [40:31] read_index
    input  logic [1:0]           s_tuser,   // [1:0] mode
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [15:0]          m_tdata,   // [9:0] entry_value
    input  logic [2:0]           m_tuser,   // [1:0] status, [2] draws_done
    output int                   failures,
    output int                   pending
);

    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [STATUS_W-1:0] status;
        logic                done;
    } answer_t;

    logic [VALUE_W-1:0] seq_store [MAX_ENTRIES];
    logic [REG_W-1:0]   seq_len;
    logic [REG_W-1:0]   draw_cap;
    int unsigned        draw_ctr;
    answer_t            answer_q [$];
    int                 fail_cnt;

    // one item against the local copy of the store
    task automatic advance_shuffle(input psh_mode_t mode, input logic [RWORD_W-1:0] rword,
                                   input logic [VALUE_W-1:0] ridx, output answer_t ans);
        int unsigned        n;
        int unsigned        lim;
        int unsigned        rw;
        int unsigned        j;
        int unsigned        i;
        logic [VALUE_W-1:0] tmp;
        n   = (seq_len > MAX_ENTRIES) ? MAX_ENTRIES : seq_len;
        lim = (draw_cap < n) ? draw_cap : n;
        rw  = rword;
        ans = '0;
        case (mode)
            MODE_RESTART:
            begin
                for (i = 0; i < n; i++)
                    seq_store[i] = VALUE_W'(i);
                draw_ctr = 0;
            end
            MODE_DRAW:
            begin
                if (draw_ctr >= lim)
                    ans.status = STATUS_EXHAUSTED;
                else
                begin
                    j = draw_ctr + (rw % (n - draw_ctr));
                    tmp = seq_store[draw_ctr];
                    seq_store[draw_ctr] = seq_store[j];
                    seq_store[j] = tmp;
                    draw_ctr++;
                end
            end
            MODE_READ:
            begin
                if (ridx < n)
                    ans.value = seq_store[ridx];
                else
                    ans.status = STATUS_RANGE;
            end
            default: ;
        endcase
        ans.done = (draw_ctr >= lim);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        answer_t fresh;
        answer_t want;
        answer_t got;
        if (!rst_n)
        begin
            seq_len  = REG_W'(1024);
            draw_cap = REG_W'(1024);
            draw_ctr = 0;
            answer_q.delete();
            fail_cnt = 0;
            failures <= 0;
            pending  <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SEQ_LEN:  seq_len  = cfg_data;
                    REG_DRAW_CNT: draw_cap = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                advance_shuffle(psh_mode_t'(s_tuser), s_tdata[RWORD_W-1:0],
                                s_tdata[RWORD_W +: VALUE_W], fresh);
                answer_q.push_back(fresh);
            end
            if (m_tvalid && m_tready)
            begin
                got.value  = m_tdata[VALUE_W-1:0];
                got.status = m_tuser[STATUS_W-1:0];
                got.done   = m_tuser[STATUS_W];
                if (answer_q.size() == 0)
                begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("unexpected result: value %0d status %0d done %0d",
                                 got.value, got.status, got.done);
                end
                else
                begin
                    want = answer_q.pop_front();
                    if (got !== want)
                    begin
                        fail_cnt++;
                        if (fail_cnt <= 10)
                            $display("mismatch: expected value %0d status %0d done %0d, got value %0d status %0d done %0d",
                                     want.value, want.status, want.done,
                                     got.value, got.status, got.done);
                    end
                end
            end
            failures <= fail_cnt;
            pending  <= answer_q.size();
        end
    end

endmodule

/* verif/partial_shuffle_engine_test.sv */
// ----------------------------------------------------------------------------
// partial_shuffle_engine_test: top of the partial shuffle engine testbench
// Drives restart, draw and read transactions in bursts under a stalling
// result channel, changes length and draw limit between phases, and leaves
// all checking to the checker instance beside the engine.
// ----------------------------------------------------------------------------
module partial_shuffle_engine_test;
    import psh_pkg::*;

    // random part size and the no-transaction limit; the slowest legal quiet
    // stretch is a full 1024-entry restart fill plus a receiver stall, so
    // the limit is set several times over that
    localparam int RANDOM_ITEMS   = 1150;
    localparam int WATCHDOG_LIMIT = 8000;
    localparam logic [RWORD_W-1:0] RWORD_MAX = '1;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index     = REG_SEQ_LEN;
    logic [REG_W-1:0]     cfg_data      = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [47:0]          s_axis_tdata  = '0;  // [30:0] random_word, [40:31] read_index
    logic [1:0]           s_axis_tuser  = MODE_NONE;  // [1:0] mode
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [15:0]          m_axis_tdata;        // [9:0] entry_value
    logic [2:0]           m_axis_tuser;        // [1:0] status, [2] draws_done

    int failures;
    int pending;
    int items_sent = 0;
    int burst_left = 0;
    int ready_hold = 0;
    int idle_cycles = 0;

    // extreme settings visited first in the random part
    int ext_len [8] = '{1, 1, 1024, 2, 1024, 1024, 1023, 3};
    int ext_cnt [8] = '{0, 1, 0, 1024, 1024, 1023, 1024, 2};

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    partial_shuffle_engine dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    shuffle_checker shuffle_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_axis_tvalid),
        .s_tready  (s_axis_tready),
        .s_tdata   (s_axis_tdata),
        .s_tuser   (s_axis_tuser),
        .m_tvalid  (m_axis_tvalid),
        .m_tready  (m_axis_tready),
        .m_tdata   (m_axis_tdata),
        .m_tuser   (m_axis_tuser),
        .failures  (failures),
        .pending   (pending)
    );

    // receiver: ready holds a level for a random stretch; mostly short
    // stalls, now and then a long stall, sometimes a long stall-free run
    always @(posedge clk)
    begin
        if (ready_hold == 0)
        begin
            case ($urandom_range(0, 7))
                0, 1, 2, 3:
                begin
                    m_axis_tready <= 1'b1;
                    ready_hold = $urandom_range(1, 40);
                end
                4, 5:
                begin
                    m_axis_tready <= 1'b0;
                    ready_hold = $urandom_range(1, 6);
                end
                6:
                begin
                    m_axis_tready <= 1'b0;
                    ready_hold = $urandom_range(8, 20);
                end
                default:
                begin
                    m_axis_tready <= 1'b1;
                    ready_hold = $urandom_range(100, 300);
                end
            endcase
        end
        else
            ready_hold--;
    end

    // watchdog: cycles with no transaction on either stream
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("partial_shuffle_engine_test: done, errors");
                $finish;
            end
        end
    end

    // random word: extremes and small values mixed into full-range words
    function automatic logic [RWORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return RWORD_MAX;
            2:       return RWORD_W'($urandom_range(0, 15));
            default: return RWORD_W'($urandom);
        endcase
    endfunction

    // read index: mostly inside the sequence, sometimes past its end
    function automatic logic [VALUE_W-1:0] pick_index(input int n);
        if (n < 1024 && $urandom_range(0, 5) == 0)
            return VALUE_W'($urandom_range(n, 1023));
        return VALUE_W'($urandom_range(0, n - 1));
    endfunction

    // one input transaction; the sender runs bursts with random gaps, and
    // valid is only lowered at the start of a gap, never within a burst
    task automatic send_item(input psh_mode_t mode, input logic [RWORD_W-1:0] rword,
                             input logic [VALUE_W-1:0] ridx);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, ridx, rword};
        s_axis_tuser  <= mode;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
    endtask

    // fully random transaction; restarts of long sequences are turned into
    // the unused mode to keep the run short
    task automatic send_noise(input int n);
        psh_mode_t mode;
        mode = psh_mode_t'($urandom_range(0, 3));
        if (mode == MODE_RESTART && n > 64)
            mode = MODE_NONE;
        send_item(mode, RWORD_W'($urandom), VALUE_W'($urandom_range(0, 1023)));
    endtask

    // stop sending and wait until every answer is back and the engine is idle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_regs(input int n, input int dc);
        cfg_we    <= 1'b1;
        cfg_index <= REG_SEQ_LEN;
        cfg_data  <= REG_W'(n);
        @(posedge clk);
        cfg_index <= REG_DRAW_CNT;
        cfg_data  <= REG_W'(dc);
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // a shuffle round: optional restart, draws (just past a small limit,
    // else a random count) with reads sprinkled in, then a few reads of the result
    task automatic shuffle_round(input int n, input int dc, input bit restart);
        int lim;
        int draws;
        int reads;
        int i;
        lim = (dc < n) ? dc : n;
        if (restart)
            send_item(MODE_RESTART, pick_word(), pick_index(n));
        if (lim <= 38 && $urandom_range(0, 3) != 0)
            draws = lim + $urandom_range(0, 2);
        else
            draws = $urandom_range(1, 40);
        for (i = 0; i < draws; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                send_noise(n);
            send_item(MODE_DRAW, pick_word(), pick_index(n));
            if ($urandom_range(0, 3) == 0)
                send_item(MODE_READ, pick_word(), pick_index(n));
        end
        reads = $urandom_range(1, 12);
        for (i = 0; i < reads; i++)
            send_item(MODE_READ, pick_word(), pick_index(n));
    endtask

    initial
    begin : stimulus
        int  base;
        int  phase;
        int  n;
        int  dc;
        int  budget;
        int  phase_start;
        bit  first;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults after reset: the very first item is a full-length restart,
        // so no later read or swap can touch a never-written entry
        send_item(MODE_RESTART, '0, '0);
        send_item(MODE_READ, '0, '0);
        send_item(MODE_READ, '0, 10'd1023);
        send_item(MODE_DRAW, '0, '0);
        send_item(MODE_DRAW, RWORD_MAX, '1);
        send_item(MODE_DRAW, RWORD_W'($urandom), '0);
        send_item(MODE_READ, '0, '0);
        send_item(MODE_READ, '0, 10'd1);
        send_item(MODE_NONE, RWORD_MAX, '1);

        // short sequence, draw limit below length: exhaust it, read past end
        drain();
        set_regs(5, 3);
        send_item(MODE_RESTART, RWORD_MAX, '1);
        send_item(MODE_DRAW, RWORD_MAX, '0);
        send_item(MODE_DRAW, '0, '0);
        send_item(MODE_DRAW, RWORD_W'(1), '0);
        send_item(MODE_DRAW, RWORD_W'(7), '0);
        send_item(MODE_READ, '0, 10'd4);
        send_item(MODE_READ, '0, 10'd5);
        send_item(MODE_READ, '0, 10'd1023);
        send_item(MODE_READ, RWORD_MAX, 10'd0);
        send_item(MODE_NONE, '0, '0);

        // limit lowered below the current counter: draws count as exhausted
        drain();
        set_regs(5, 1);
        send_item(MODE_DRAW, RWORD_W'($urandom), '0);
        send_item(MODE_READ, '0, 10'd2);

        base  = items_sent;
        phase = 0;
        while (items_sent - base < RANDOM_ITEMS)
        begin
            if (phase < 8)
            begin
                n  = ext_len[phase];
                dc = ext_cnt[phase];
            end
            else
            begin
                case ($urandom_range(0, 7))
                    0:       n = 1024;
                    1:       n = $urandom_range(512, 1024);
                    default: n = $urandom_range(1, 48);
                endcase
                case ($urandom_range(0, 5))
                    0:       dc = 0;
                    1:       dc = n;
                    2:       dc = n - 1;
                    3:       dc = $urandom_range(0, n);
                    4:       dc = 1024;
                    default: dc = $urandom_range(0, 1024);
                endcase
            end
            drain();
            set_regs(n, dc);
            budget      = $urandom_range(50, 120);
            phase_start = items_sent;
            first       = 1'b1;
            while (items_sent - phase_start < budget && items_sent - base < RANDOM_ITEMS)
            begin
                // long fills are costly, so restart them less often; a round
                // without restart keeps drawing from the old counter
                if (n > 256)
                    shuffle_round(n, dc, $urandom_range(0, first ? 3 : 7) == 0);
                else
                    shuffle_round(n, dc, $urandom_range(0, first ? 3 : 1) != 0);
                first = 1'b0;
            end
            phase++;
        end

        drain();
        repeat (50) @(posedge clk);
        if (failures == 0 && pending == 0)
            $display("partial_shuffle_engine_test: done, clean");
        else
            $display("partial_shuffle_engine_test: done, errors");
        $finish;
    end

endmodule
